[rtl/multi_timer_sorted_expiry_core_macros.svh]
// assertion macros used by the timer pool datapath
`ifndef MULTI_TIMER_SORTED_EXPIRY_CORE_MACROS_SVH
`define MULTI_TIMER_SORTED_EXPIRY_CORE_MACROS_SVH

// condition must hold at every clock edge outside reset
`define MTSE_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold whenever the antecedent holds
`define MTSE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/mtse_pkg.sv]
// shared types and constants of the timer pool
package mtse_pkg;

   localparam int TICK_W      = 32;
   localparam int TAG_W       = 32;
   localparam int SLOT_IN_W   = 4;
   localparam int ID_W        = 4;
   localparam int TSS_W       = 5;
   localparam logic [TSS_W-1:0] TSS_NONE = 5'd16;
   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = 5;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_ARM   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_GRANTED     = 3'd0,
      KIND_NONE_FREE   = 3'd1,
      KIND_EXPIRED     = 3'd2,
      KIND_TASK_SWITCH = 3'd3,
      KIND_REFUSED     = 3'd4
   } kind_type;

   // controller to datapath
   typedef struct packed {
      logic latch_req;
      logic tick_inc;
      logic scan_clr;
      logic scan_inc;
      logic grant;
      logic none_free;
      logic refuse;
      logic free_slot;
      logic arm_start;
      logic rd_walk;
      logic rd_head;
      logic walk_adv;
      logic link_self;
      logic link_prev;
      logic expire;
      logic set_earliest;
      logic clear_earliest;
      logic push_last;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    slot_ok;
      logic    slot_alloc;
      logic    slot_run;
      logic    scan_done;
      logic    scan_free;
      logic    not_due;
      logic    walk_end;
      logic    walk_stop;
      logic    head_nil;
      logic    tick_stop;
      logic    pend_valid;
      logic    out_free;
   } ctrl_sts_type;

endpackage

[rtl/mtse_dp.sv]
// timer pool datapath: slot state, memories, sorted list walk, result registers
`include "multi_timer_sorted_expiry_core_macros.svh"

module mtse_dp #(
   parameter int SLOTS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mtse_pkg::ctrl_cmd_type                cmd,
   output mtse_pkg::ctrl_sts_type                sts,
   input  mtse_pkg::cmd_type                     req_cmd,
   input  logic [mtse_pkg::SLOT_IN_W-1:0]        req_slot,
   input  logic [mtse_pkg::TICK_W-1:0]           req_timeout,
   input  logic [mtse_pkg::TAG_W-1:0]            req_data,
   input  logic                                  csr_we,
   input  logic [mtse_pkg::TSS_W-1:0]            csr_wdata,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output mtse_pkg::kind_type                    rsp_kind,
   output logic [mtse_pkg::ID_W-1:0]             rsp_id,
   output logic [mtse_pkg::TAG_W-1:0]            rsp_tag,
   output logic                                  rsp_last
);
   import mtse_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LINK_W = $clog2(SLOTS + 1);
   localparam int CMP_W  = (SLOT_W > TSS_W) ? SLOT_W : TSS_W;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

   // latched transaction
   cmd_type                req_cmd_ff, req_cmd_in;
   logic [SLOT_IN_W-1:0]   req_slot_ff, req_slot_in;
   logic [TICK_W-1:0]      req_timeout_ff, req_timeout_in;
   logic [TAG_W-1:0]       req_data_ff, req_data_in;

   logic [TSS_W-1:0]       tss_ff, tss_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [SLOTS-1:0]       alloc_ff, alloc_in;
   logic [SLOTS-1:0]       run_ff, run_in;
   logic [LINK_W-1:0]      head_ff, head_in;
   logic [TICK_W-1:0]      earliest_ff, earliest_in;
   logic [LINK_W-1:0]      scan_ff, scan_in;
   logic [LINK_W-1:0]      cur_ff, cur_in;
   logic [LINK_W-1:0]      prev_ff, prev_in;
   logic [LINK_W-1:0]      guard_ff, guard_in;
   logic [TICK_W-1:0]      arm_dl_ff, arm_dl_in;
   logic [RES_CNT_W-1:0]   n_ff, n_in;

   logic                   pend_valid_ff, pend_valid_in;
   kind_type               pend_kind_ff, pend_kind_in;
   logic [ID_W-1:0]        pend_id_ff, pend_id_in;
   logic [TAG_W-1:0]       pend_tag_ff, pend_tag_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   kind_type               rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic [TAG_W-1:0]       rsp_tag_ff, rsp_tag_in;
   logic                   rsp_last_ff, rsp_last_in;

   // slot memories
   logic [TICK_W-1:0]      dl_mem   [SLOTS];
   logic [TAG_W-1:0]       tag_mem  [SLOTS];
   logic [LINK_W-1:0]      link_mem [SLOTS];
   logic [TICK_W-1:0]      dl_rd_ff;
   logic [TAG_W-1:0]       tag_rd_ff;
   logic [LINK_W-1:0]      link_rd_ff;

   logic [SLOT_W-1:0]      req_idx;
   logic [SLOT_W-1:0]      head_idx;
   logic [SLOT_W-1:0]      cur_idx;
   logic [SLOT_W-1:0]      prev_idx;
   logic [SLOT_W-1:0]      scan_idx;
   logic [SLOT_W-1:0]      rd_addr;
   logic                   rd_en;
   logic [TICK_W-1:0]      arm_sum;
   logic                   is_ts;
   logic                   prev_nil;
   logic                   link_we;
   logic [SLOT_W-1:0]      link_waddr;
   logic [LINK_W-1:0]      link_wdata;

   assign req_idx  = SLOT_W'(req_slot_ff);
   assign head_idx = head_ff[SLOT_W-1:0];
   assign cur_idx  = cur_ff[SLOT_W-1:0];
   assign prev_idx = prev_ff[SLOT_W-1:0];
   assign scan_idx = scan_ff[SLOT_W-1:0];
   assign arm_sum  = tick_ff + req_timeout_ff;
   assign is_ts    = (CMP_W'(head_idx) == CMP_W'(tss_ff));
   assign prev_nil = (prev_ff >= NIL);
   assign rd_en    = cmd.rd_walk | cmd.rd_head;
   assign rd_addr  = cmd.rd_walk ? cur_idx : head_idx;

   assign link_we    = cmd.link_self | (cmd.link_prev & ~prev_nil);
   assign link_waddr = cmd.link_self ? req_idx : prev_idx;
   assign link_wdata = cmd.link_self ? cur_ff : LINK_W'(req_idx);

   always_comb begin
      sts.cmd        = req_cmd_ff;
      sts.slot_ok    = (32'(req_slot_ff) < 32'(SLOTS));
      sts.slot_alloc = alloc_ff[req_idx];
      sts.slot_run   = run_ff[req_idx];
      sts.scan_done  = (scan_ff == NIL);
      sts.scan_free  = ~alloc_ff[scan_idx];
      sts.not_due    = (earliest_ff > tick_ff);
      sts.walk_end   = (cur_ff >= NIL) || (guard_ff == NIL);
      sts.walk_stop  = (arm_dl_ff <= dl_rd_ff);
      sts.head_nil   = (head_ff >= NIL);
      sts.tick_stop  = (dl_rd_ff > tick_ff) || (n_ff == RES_CNT_W'(MAX_RESULTS));
      sts.pend_valid = pend_valid_ff;
      sts.out_free   = ~rsp_valid_ff | rsp_ready;
   end

   always_comb begin
      logic rsp_load;
      logic rsp_load_last;
      rsp_load       = 1'b0;
      rsp_load_last  = 1'b0;
      req_cmd_in     = req_cmd_ff;
      req_slot_in    = req_slot_ff;
      req_timeout_in = req_timeout_ff;
      req_data_in    = req_data_ff;
      tss_in         = tss_ff;
      tick_in        = tick_ff;
      alloc_in       = alloc_ff;
      run_in         = run_ff;
      head_in        = head_ff;
      earliest_in    = earliest_ff;
      scan_in        = scan_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      guard_in       = guard_ff;
      arm_dl_in      = arm_dl_ff;
      n_in           = n_ff;
      pend_valid_in  = pend_valid_ff;
      pend_kind_in   = pend_kind_ff;
      pend_id_in     = pend_id_ff;
      pend_tag_in    = pend_tag_ff;

      if (cmd.latch_req) begin
         req_cmd_in     = req_cmd;
         req_slot_in    = req_slot;
         req_timeout_in = req_timeout;
         req_data_in    = req_data;
      end
      if (csr_we) begin
         tss_in = csr_wdata;
      end
      if (cmd.tick_inc) begin
         tick_in = tick_ff + 1'b1;
         n_in    = '0;
      end
      if (cmd.scan_clr) begin
         scan_in = '0;
      end
      if (cmd.scan_inc) begin
         scan_in = scan_ff + 1'b1;
      end
      if (cmd.grant) begin
         alloc_in[scan_idx] = 1'b1;
         pend_valid_in      = 1'b1;
         pend_kind_in       = KIND_GRANTED;
         pend_id_in         = ID_W'(scan_idx);
         pend_tag_in        = '0;
      end
      if (cmd.none_free) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = KIND_NONE_FREE;
         pend_id_in    = '0;
         pend_tag_in   = '0;
      end
      if (cmd.refuse) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = KIND_REFUSED;
         pend_id_in    = req_slot_ff;
         pend_tag_in   = '0;
      end
      if (cmd.free_slot) begin
         alloc_in[req_idx] = 1'b0;
      end
      if (cmd.arm_start) begin
         run_in[req_idx] = 1'b1;
         arm_dl_in       = arm_sum;
         cur_in          = head_ff;
         prev_in         = NIL;
         guard_in        = '0;
      end
      if (cmd.walk_adv) begin
         prev_in  = cur_ff;
         cur_in   = link_rd_ff;
         guard_in = guard_ff + 1'b1;
      end
      if (cmd.link_prev && prev_nil) begin
         head_in     = LINK_W'(req_idx);
         earliest_in = arm_dl_ff;
      end
      if (cmd.expire) begin
         rsp_load         = pend_valid_ff;
         run_in[head_idx] = 1'b0;
         head_in          = link_rd_ff;
         n_in             = n_ff + 1'b1;
         pend_valid_in    = 1'b1;
         pend_kind_in     = is_ts ? KIND_TASK_SWITCH : KIND_EXPIRED;
         pend_id_in       = ID_W'(head_idx);
         pend_tag_in      = is_ts ? '0 : tag_rd_ff;
      end
      if (cmd.set_earliest) begin
         earliest_in = dl_rd_ff;
      end
      if (cmd.clear_earliest) begin
         earliest_in = '1;
      end
      if (cmd.push_last) begin
         rsp_load      = 1'b1;
         rsp_load_last = 1'b1;
         pend_valid_in = 1'b0;
      end

      rsp_kind_in = rsp_kind_ff;
      rsp_id_in   = rsp_id_ff;
      rsp_tag_in  = rsp_tag_ff;
      rsp_last_in = rsp_last_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = pend_kind_ff;
         rsp_id_in    = pend_id_ff;
         rsp_tag_in   = pend_tag_ff;
         rsp_last_in  = rsp_load_last;
      end else begin
         rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tss_ff        <= TSS_NONE;
         tick_ff       <= '0;
         alloc_ff      <= '0;
         run_ff        <= '0;
         head_ff       <= NIL;
         earliest_ff   <= '1;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tss_ff        <= tss_in;
         tick_ff       <= tick_in;
         alloc_ff      <= alloc_in;
         run_ff        <= run_in;
         head_ff       <= head_in;
         earliest_ff   <= earliest_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_cmd_ff     <= req_cmd_in;
      req_slot_ff    <= req_slot_in;
      req_timeout_ff <= req_timeout_in;
      req_data_ff    <= req_data_in;
      scan_ff        <= scan_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      guard_ff       <= guard_in;
      arm_dl_ff      <= arm_dl_in;
      n_ff           <= n_in;
      pend_kind_ff   <= pend_kind_in;
      pend_id_ff     <= pend_id_in;
      pend_tag_ff    <= pend_tag_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // one write and one registered read per cycle on each memory
   always_ff @(posedge clock) begin
      if (cmd.arm_start) begin
         dl_mem[req_idx]  <= arm_sum;
         tag_mem[req_idx] <= req_data_ff;
      end
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (rd_en) begin
         dl_rd_ff   <= dl_mem[rd_addr];
         tag_rd_ff  <= tag_mem[rd_addr];
         link_rd_ff <= link_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_id    = rsp_id_ff;
   assign rsp_tag   = rsp_tag_ff;
   assign rsp_last  = rsp_last_ff;

   `MTSE_ASSERT_ALWAYS(a_run_is_alloc, clock, reset, (run_ff & ~alloc_ff) == '0, "running slot not allocated")
   `MTSE_ASSERT_IMPLY(a_head_running, clock, reset, head_ff < NIL, run_ff[head_idx], "list head not running")
   `MTSE_ASSERT_IMPLY(a_single_last, clock, reset, rsp_valid_ff && (rsp_kind_ff == KIND_GRANTED || rsp_kind_ff == KIND_NONE_FREE || rsp_kind_ff == KIND_REFUSED), rsp_last_ff, "single result without last")

endmodule

[rtl/mtse_ctrl.sv]
// timer pool controller: sequences commands, list walks and result pushes
module mtse_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mtse_pkg::ctrl_sts_type sts,
   output mtse_pkg::ctrl_cmd_type cmd
);
   import mtse_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_TICK_CMP,
      ST_TICK_RD,
      ST_TICK_CHK,
      ST_ALLOC_SCAN,
      ST_WALK_RD,
      ST_WALK_CMP,
      ST_LINK_SELF,
      ST_LINK_PREV,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (sts.cmd)
               CMD_TICK: begin
                  cmd.tick_inc = 1'b1;
                  state_in     = ST_TICK_CMP;
               end
               CMD_ALLOC: begin
                  cmd.scan_clr = 1'b1;
                  state_in     = ST_ALLOC_SCAN;
               end
               CMD_FREE: begin
                  if (!sts.slot_ok || sts.slot_run) begin
                     cmd.refuse = 1'b1;
                     state_in   = ST_FINISH;
                  end else begin
                     cmd.free_slot = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
               CMD_ARM: begin
                  if (!sts.slot_ok || !sts.slot_alloc || sts.slot_run) begin
                     cmd.refuse = 1'b1;
                     state_in   = ST_FINISH;
                  end else begin
                     cmd.arm_start = 1'b1;
                     state_in      = ST_WALK_RD;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_TICK_CMP: begin
            state_in = sts.not_due ? ST_IDLE : ST_TICK_RD;
         end
         ST_TICK_RD: begin
            if (sts.head_nil) begin
               cmd.clear_earliest = 1'b1;
               state_in           = ST_FINISH;
            end else begin
               cmd.rd_head = 1'b1;
               state_in    = ST_TICK_CHK;
            end
         end
         ST_TICK_CHK: begin
            if (sts.tick_stop) begin
               cmd.set_earliest = 1'b1;
               state_in         = ST_FINISH;
            end else if (!sts.pend_valid || sts.out_free) begin
               cmd.expire = 1'b1;
               state_in   = ST_TICK_RD;
            end
         end
         ST_ALLOC_SCAN: begin
            if (sts.scan_done) begin
               cmd.none_free = 1'b1;
               state_in      = ST_FINISH;
            end else if (sts.scan_free) begin
               cmd.grant = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         ST_WALK_RD: begin
            if (sts.walk_end) begin
               state_in = ST_LINK_SELF;
            end else begin
               cmd.rd_walk = 1'b1;
               state_in    = ST_WALK_CMP;
            end
         end
         ST_WALK_CMP: begin
            if (sts.walk_stop) begin
               state_in = ST_LINK_SELF;
            end else begin
               cmd.walk_adv = 1'b1;
               state_in     = ST_WALK_RD;
            end
         end
         ST_LINK_SELF: begin
            cmd.link_self = 1'b1;
            state_in      = ST_LINK_PREV;
         end
         ST_LINK_PREV: begin
            cmd.link_prev = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_FINISH: begin
            if (!sts.pend_valid) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.push_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

[rtl/multi_timer_sorted_expiry_core.sv]
// top level of the timer pool with sorted expiry list
// one request is taken at a time: req_tready stays low until the controller is idle again; alloc
// scans the slots one by one, arm walks the sorted list to its place, tick expires each due timer
// in turn; one read port on the slot memories paces the list walk and rsp_tready stalls hold the
// result pushes; the last result is registered as req_tready rises for the next request; reset is
// synchronous and clears slot state, tick, list head, earliest deadline, task switch slot and valid flags
module multi_timer_sorted_expiry_core #(
   parameter int SLOTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // slot[3:0], timeout_ticks[35:4], data_tag[67:36], zero pad [71:68]
   input  logic [mtse_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // cmd[1:0]
   input  logic [1:0]                          req_tuser,
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // slot_id[3:0], tag[35:4]; zero pad [39:36]
   output logic [mtse_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // kind[2:0]
   output logic [2:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   // task switch slot register
   input  logic                                csr_we,
   input  logic [mtse_pkg::TSS_W-1:0]          csr_wdata
);
   import mtse_pkg::*;

   ctrl_cmd_type        cmd;
   ctrl_sts_type        sts;
   kind_type            rsp_kind;
   logic [ID_W-1:0]     rsp_id;
   logic [TAG_W-1:0]    rsp_tag;
   cmd_type             req_cmd;

   // unpack the request transaction
   assign req_cmd = cmd_type'(req_tuser);

   // controller walks the list and issues one datapath step per cycle, waiting while the result register is full
   mtse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // slot state, memories and the output register
   mtse_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_cmd     (req_cmd),
      .req_slot    (req_tdata[3:0]),
      .req_timeout (req_tdata[35:4]),
      .req_data    (req_tdata[67:36]),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_kind    (rsp_kind),
      .rsp_id      (rsp_id),
      .rsp_tag     (rsp_tag),
      .rsp_last    (rsp_tlast)
   );

   // pack the result transaction
   assign rsp_tdata = {4'b0000, rsp_tag, rsp_id};
   assign rsp_tuser = rsp_kind;

endmodule
